FILE: rtl/mm_pkg.sv
// Shared types, codes and constants of the matrix multiply block.
`timescale 1ns / 1ps
package mm_pkg;

  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIM_W         = 4;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned PROD_W        = 2 * VAL_W;
  // products plus log2 of the deepest sum plus a sign guard
  localparam int unsigned ACC_W         = PROD_W + 4;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MUL    = 2'd2,
    OP_NONE   = 2'd3
  } mm_op_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } mm_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_WAIT,
    S_SHIFT,
    S_ERR
  } mm_state_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] product;
    logic                    last;
    logic                    dims_error;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic shift;
  } cell_ctl_t;

  // clamp a dimension register to 1..maxd
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                               input int unsigned maxd);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (int'(d) > int'(maxd)) r = DIM_W'(maxd);
    return r;
  endfunction

endpackage

FILE: rtl/mm_if.sv
// Stream and configuration interfaces of the matrix multiply block.
`timescale 1ns / 1ps
interface mm_in_if import mm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mm_out_if import mm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mm_cfg_if import mm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [DIM_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mm_store.sv
// Element stores of both matrices: one A word and one whole B row per read.
`timescale 1ns / 1ps
module mm_store import mm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk_i,
  input  logic                    we_a_i,
  input  logic                    we_b_i,
  input  logic [IDX_W-1:0]        wrow_i,
  input  logic [IDX_W-1:0]        wcol_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic                    rd_i,
  input  logic [DIM_W-1:0]        ri_i,
  input  logic [DIM_W-1:0]        rk_i,
  output logic signed [VAL_W-1:0] a_o,
  output logic signed [VAL_W-1:0] b_row_o [MAX_DIM]
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [VAL_W-1:0] a_mem [DEPTH];
  logic signed [VAL_W-1:0] b_mem [MAX_DIM][MAX_DIM];
  logic [AW-1:0]           a_waddr;
  logic [AW-1:0]           a_raddr;

  assign a_waddr = AW'(int'(wrow_i) * MAX_DIM + int'(wcol_i));
  assign a_raddr = AW'(int'(ri_i) * MAX_DIM + int'(rk_i));

  always_ff @(posedge clk_i) begin
    if (we_a_i) a_mem[a_waddr] <= wdata_i;
    if (we_b_i) b_mem[RW'(wrow_i)][RW'(wcol_i)] <= wdata_i;
    if (rd_i) begin
      a_o     <= a_mem[a_raddr];
      b_row_o <= b_mem[RW'(rk_i)];
    end
  end

endmodule

FILE: rtl/mm_cell.sv
// One column cell: multiply-accumulate, then shift its sum toward the output.
`timescale 1ns / 1ps
module mm_cell import mm_pkg::*; (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [PROD_W-1:0] p_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) acc_d = '0;
    else if (ctl_i.acc_en) acc_d = acc_q + ACC_W'(p_q);
    else if (ctl_i.shift) acc_d = acc_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) p_q <= a_i * b_i;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/matrix_multiply.sv
// Matrix multiply top level: configuration, sequencer, cell chain and output stage.
//
// Load beats stream back to back. In a multiply of an ar x n by n x bc pair,
// per product row the sequencer reads n A words and n B rows from the stores,
// the chain of MAX_DIM column cells accumulates them through a registered
// multiplier, a wait state drains the pipeline, and bc sums shift out of cell 0
// through rounding and saturation, one per cycle of output ready.
// A dimension mismatch gives one error result. No new beat is taken until the
// last result of a multiply has entered the output register.
`timescale 1ns / 1ps
module matrix_multiply import mm_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input logic   clk_i,
  input logic   rst_ni,
  mm_cfg_if.sink  cfg_i,
  mm_in_if.sink   in_i,
  mm_out_if.source out_o
);

  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'((2 ** FRAC_BITS) / 2);
  localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] P_MIN = -P_MAX - ACC_W'(1);

  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [DIM_W-1:0] ar, ac, br, bc;
  mm_state_e        state_q, state_d;
  logic [DIM_W-1:0] i_q, k_q, j_q;
  logic             wait_q;
  logic             rv_q, mv_q;
  logic             ov_q;
  out_item_t        od_q;
  logic             in_acc, mul_go, out_free;
  logic             rd_issue, shift_go, err_go;
  logic             k_last, j_last, i_last;
  cell_ctl_t        ctl;

  logic signed [VAL_W-1:0] a_rd;
  logic signed [VAL_W-1:0] b_row [MAX_DIM];
  logic signed [ACC_W-1:0] chain [MAX_DIM+1];
  logic signed [ACC_W-1:0] rsum, rsh;
  logic signed [VAL_W-1:0] prod;
  logic                    sat;
  logic                    in_range;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DIM_W'(1);
      a_cols_q <= DIM_W'(1);
      b_rows_q <= DIM_W'(1);
      b_cols_q <= DIM_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_A_ROWS: a_rows_q <= cfg_i.data;
        REG_A_COLS: a_cols_q <= cfg_i.data;
        REG_B_ROWS: b_rows_q <= cfg_i.data;
        REG_B_COLS: b_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign ar = eff_dim(a_rows_q, MAX_DIM);
  assign ac = eff_dim(a_cols_q, MAX_DIM);
  assign br = eff_dim(b_rows_q, MAX_DIM);
  assign bc = eff_dim(b_cols_q, MAX_DIM);

  assign in_acc   = in_i.valid && in_i.ready;
  assign mul_go   = in_acc && (in_i.data.opcode == OP_MUL);
  assign out_free = !ov_q || out_o.ready;
  assign k_last   = (k_q == ac - DIM_W'(1));
  assign j_last   = (j_q == bc - DIM_W'(1));
  assign i_last   = (i_q == ar - DIM_W'(1));
  assign in_range = (int'(in_i.data.row) < int'(MAX_DIM)) &&
                    (int'(in_i.data.col) < int'(MAX_DIM));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (mul_go) state_d = (ac != br) ? S_ERR : S_MAC;
      S_MAC:   if (k_last) state_d = S_WAIT;
      S_WAIT:  if (wait_q) state_d = S_SHIFT;
      S_SHIFT: if (out_free && j_last) state_d = i_last ? S_IDLE : S_MAC;
      S_ERR:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    rd_issue   = 1'b0;
    shift_go   = 1'b0;
    err_go     = 1'b0;
    case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_MAC:   rd_issue   = 1'b1;
      S_SHIFT: shift_go   = out_free;
      S_ERR:   err_go     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      wait_q  <= 1'b0;
      rv_q    <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rd_issue;
      mv_q    <= rv_q;
      if (mul_go) begin
        i_q <= '0;
        k_q <= '0;
        j_q <= '0;
      end
      if (rd_issue) k_q <= k_last ? '0 : k_q + DIM_W'(1);
      if (state_q == S_WAIT) wait_q <= ~wait_q;
      if (shift_go) begin
        j_q <= j_last ? '0 : j_q + DIM_W'(1);
        if (j_last) i_q <= i_q + DIM_W'(1);
      end
    end
  end

  mm_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk_i   (clk_i),
    .we_a_i  (in_acc && (in_i.data.opcode == OP_LOAD_A) && in_range),
    .we_b_i  (in_acc && (in_i.data.opcode == OP_LOAD_B) && in_range),
    .wrow_i  (in_i.data.row),
    .wcol_i  (in_i.data.col),
    .wdata_i (in_i.data.value),
    .rd_i    (rd_issue),
    .ri_i    (i_q),
    .rk_i    (k_q),
    .a_o     (a_rd),
    .b_row_o (b_row)
  );

  // clear at the first read of a row; each read passes the store and product registers before it is accumulated
  assign ctl.clear  = rd_issue && (k_q == '0);
  assign ctl.mul_en = rv_q;
  assign ctl.acc_en = mv_q;
  assign ctl.shift  = shift_go;

  assign chain[MAX_DIM] = '0;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    mm_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .a_i   (a_rd),
      .b_i   (b_row[g]),
      .acc_i (chain[g+1]),
      .acc_o (chain[g])
    );
  end

  // round half up, then clip to 32 bits
  always_comb begin
    rsum = chain[0] + HALF;
    rsh  = rsum >>> FRAC_BITS;
    sat  = 1'b0;
    prod = VAL_W'(rsh);
    if (rsh > P_MAX) begin
      sat  = 1'b1;
      prod = VAL_W'(P_MAX);
    end else if (rsh < P_MIN) begin
      sat  = 1'b1;
      prod = VAL_W'(P_MIN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (shift_go || err_go) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_go) begin
      od_q.out_row    <= IDX_W'(i_q);
      od_q.out_col    <= IDX_W'(j_q);
      od_q.product    <= prod;
      od_q.last       <= i_last && j_last;
      od_q.dims_error <= 1'b0;
      od_q.saturated  <= sat;
    end else if (err_go) begin
      od_q.out_row    <= '0;
      od_q.out_col    <= '0;
      od_q.product    <= '0;
      od_q.last       <= 1'b1;
      od_q.dims_error <= 1'b1;
      od_q.saturated  <= 1'b0;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

  a_shift_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_go |=> ov_q)
    else $error("shifted sum did not reach the output register");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && od_q.dims_error) |-> od_q.last)
    else $error("error result without last mark");

  a_no_clear_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.clear && (ctl.acc_en || ctl.shift)))
    else $error("row clear collides with accumulate or shift");

  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_go |=> (state_q != S_IDLE))
    else $error("multiply beat left the sequencer idle");

endmodule
